FILE: rtl/sks_pkg.sv
// Shared constants, widths and sequencer state type for the sorted key search block.
package sks_pkg;

   // Fixed port widths
   localparam int KEY_W   = 64;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int PROBE_W = 4;
   localparam int BYTE_W  = 8;
   localparam int KEY_MAX_BYTES = KEY_W / BYTE_W;

   // Parameter defaults
   localparam int DEF_TABLE_DEPTH = 1024;
   localparam int DEF_KEY_BYTES   = 8;

   // Request action codes
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   // Search sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE
   } sks_state_type;

endpackage

FILE: rtl/sorted_key_binary_search.sv
// Top level: key table with an iterative binary search sequencer.
//
//   port group     direction  handshake              payload
//   req_*          in         start & !busy           action, search_key, load_index
//   rsp_*          out        rsp_valid, 1 cycle      found, position, probe_count
//   csr_*          in         csr_we                  entry_count
//
// A load request writes the key table in the cycle it is accepted, when
// req_load_index is below TABLE_DEPTH; busy stays low. A search request runs
// a probe state (midpoint address, registered read of the single RAM port) and
// a compare state for each probe, and on a miss ends in a probe with crossed bounds.
// rsp_valid rises in the cycle busy falls; a new request may be taken then.
// The receiver cannot stall. Reset clears entry_count and the sequencer; the
// key table is not cleared.
module sorted_key_binary_search
   import sks_pkg::*;
   #(parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
     parameter int KEY_BYTES   = DEF_KEY_BYTES)
   (input  logic               clock,
    input  logic               reset,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic               req_action,
    input  logic [KEY_W-1:0]   req_search_key,
    input  logic [INDEX_W-1:0] req_load_index,
    // result channel
    output logic               rsp_valid,
    output logic               rsp_found,
    output logic [INDEX_W-1:0] rsp_position,
    output logic [PROBE_W-1:0] rsp_probe_count,
    // configuration
    input  logic               csr_we,
    input  logic [COUNT_W-1:0] csr_entry_count);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [KEY_W-1:0] KEY_MASK =
      {KEY_W{1'b1}} << (BYTE_W * (KEY_MAX_BYTES - KEY_BYTES));

   sks_state_type state_ff, state_in;

   logic [COUNT_W-1:0] entry_count_ff;
   logic [CW-1:0]      lo_ff, lo_in;        // inclusive lower bound
   logic [CW-1:0]      hi_ff, hi_in;        // exclusive upper bound
   logic [AW-1:0]      mid_ff, mid_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [PROBE_W-1:0] probes_ff, probes_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0] rsp_position_ff, rsp_position_in;
   logic [PROBE_W-1:0] rsp_probe_count_ff, rsp_probe_count_in;

   logic               accept;
   logic               load_ok;
   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [KEY_W-1:0]   ram_rdata;
   logic [KEY_W-1:0]   probe_key;
   logic               range_open;
   logic [CW:0]        mid_sum;
   logic [AW-1:0]      mid_calc;
   logic [CW-1:0]      count_clamped;
   logic [PROBE_W-1:0] probes_inc;
   logic               key_hit;
   logic               key_less;

   // Key table
   sks_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_search_key),
      .rdata (ram_rdata));

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_we) begin
         entry_count_ff <= csr_entry_count;
      end
   end

   // Shared datapath: midpoint, compare, saturating probe counter
   assign accept        = start && !busy;
   assign load_ok       = 32'(req_load_index) < TABLE_DEPTH;
   assign ram_we        = accept && (req_action == ACT_LOAD) && load_ok;
   assign range_open    = lo_ff < hi_ff;
   assign mid_sum       = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
   assign mid_calc      = AW'(mid_sum >> 1);
   assign ram_addr      = ram_we ? AW'(req_load_index) : mid_calc;
   assign count_clamped = (32'(entry_count_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                              : CW'(entry_count_ff);
   assign probe_key     = ram_rdata & KEY_MASK;
   assign key_hit       = key_ff == probe_key;
   assign key_less      = key_ff < probe_key;
   assign probes_inc    = (probes_ff == {PROBE_W{1'b1}}) ? probes_ff
                                                         : probes_ff + PROBE_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_SEARCH)) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            state_in = range_open ? ST_COMPARE : ST_IDLE;
         end
         ST_COMPARE: begin
            state_in = key_hit ? ST_IDLE : ST_PROBE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates and result
   always_comb begin
      lo_in              = lo_ff;
      hi_in              = hi_ff;
      mid_in             = mid_ff;
      key_in             = key_ff;
      probes_in          = probes_ff;
      rsp_valid_in       = 1'b0;
      rsp_found_in       = rsp_found_ff;
      rsp_position_in    = rsp_position_ff;
      rsp_probe_count_in = rsp_probe_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_SEARCH)) begin
               lo_in     = '0;
               hi_in     = count_clamped;
               key_in    = req_search_key & KEY_MASK;
               probes_in = '0;
            end
         end
         ST_PROBE: begin
            mid_in = mid_calc;
            if (!range_open) begin
               // bounds crossed: not found
               rsp_valid_in       = 1'b1;
               rsp_found_in       = 1'b0;
               rsp_position_in    = '0;
               rsp_probe_count_in = probes_ff;
            end
         end
         ST_COMPARE: begin
            probes_in = probes_inc;
            if (key_hit) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = 1'b1;
               rsp_position_in    = INDEX_W'(mid_ff);
               rsp_probe_count_in = probes_inc;
            end else if (key_less) begin
               hi_in = CW'(mid_ff);
            end else begin
               lo_in = CW'(mid_ff) + CW'(1);
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lo_ff              <= lo_in;
      hi_ff              <= hi_in;
      mid_ff             <= mid_in;
      key_ff             <= key_in;
      probes_ff          <= probes_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_position_ff    <= rsp_position_in;
      rsp_probe_count_ff <= rsp_probe_count_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_probe_count = rsp_probe_count_ff;

endmodule

FILE: rtl/sks_ram.sv
// Generic single-port RAM with registered read data.
module sks_ram
   #(parameter int WIDTH = 64,
     parameter int DEPTH = 1024,
     localparam int AW = $clog2(DEPTH))
   (input  logic             clock,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write when we is high; the output register always takes the old data at addr
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/sks_checker.sv
// Port-level checker for the sorted key search block, with its bind.
module sks_checker
   import sks_pkg::*;
   (input logic               clock,
    input logic               reset,
    input logic               start,
    input logic               busy,
    input logic               req_action,
    input logic               rsp_valid,
    input logic               rsp_found,
    input logic [INDEX_W-1:0] rsp_position,
    input logic [PROBE_W-1:0] rsp_probe_count);

   // A search request always raises busy in the cycle after it is accepted
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_SEARCH) |=> busy)
      else $error("search request did not raise busy");

   // A load request completes at once and produces no result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_LOAD) |=> (!busy && !rsp_valid))
      else $error("load request raised busy or a result");

   // The end of a search always shows its result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("search ended without a result");

   // A miss reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_position == '0))
      else $error("not-found result with nonzero position");

   // A hit needs at least one probe
   a_hit_probe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_probe_count != '0))
      else $error("found result after zero probes");

endmodule

bind sorted_key_binary_search sks_checker u_sks_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_action      (req_action),
   .rsp_valid       (rsp_valid),
   .rsp_found       (rsp_found),
   .rsp_position    (rsp_position),
   .rsp_probe_count (rsp_probe_count));
